### rtl/mia_pkg.sv
`default_nettype none
package mia_pkg;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIVST = 3'd3,
        OP_EMIT  = 3'd4
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] addr_a;
        logic [3:0] addr_b;
        logic [1:0] acc_sel;
        logic       acc_clr;
        logic       acc_neg;
        logic [3:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } status_t;

endpackage
`default_nettype wire

### rtl/mia_ctrl.sv
`default_nettype none
module mia_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_beat,
    input  wire mia_pkg::status_t stat,
    output logic                  s_ready,
    output logic                  start,
    output logic [3:0]            load_addr
);
    import mia_pkg::*;

    typedef enum logic [1:0] {ST_LOAD, ST_START, ST_WAIT} state_t;

    state_t     state_reg;
    logic [3:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (in_beat) begin
                        cnt_reg <= cnt_reg + 4'd1;
                        if (cnt_reg == 4'd15) state_reg <= ST_START;
                    end
                end
                ST_START: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (!stat.div_busy && !stat.out_full) state_reg <= ST_LOAD;
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_LOAD);
    assign start     = (state_reg == ST_START);
    assign load_addr = cnt_reg;
endmodule
`default_nettype wire

### rtl/mia_dp.sv
`default_nettype none
module mia_dp #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_beat,
    input  wire logic [3:0]                   load_addr,
    input  wire logic signed [DATA_WIDTH-1:0] in_value,
    input  wire logic                         start,
    output mia_pkg::status_t                  stat,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_value,
    output logic [3:0]                        m_index,
    output logic                              m_singular,
    output logic                              m_sat,
    output logic                              m_last
);
    import mia_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int BW = DATA_WIDTH + 1;
    localparam int PR = 2 * DATA_WIDTH + 1;
    localparam int MW = 3 * DATA_WIDTH + 4;
    localparam int DW = 4 * DATA_WIDTH + 4;
    localparam int NW = MW + 2 * FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [2:0] {
        P_IDLE, P_MIN, P_DET, P_DIV, P_OUT
    } phase_t;

    logic signed [DATA_WIDTH-1:0] mem_reg [16];
    always_ff @(posedge aclk) begin
        if (in_beat) mem_reg[load_addr] <= in_value;
    end

    // one shared multiplier; per minor term: two 2x2 products, then the
    // element times the low and high halves of their difference
    phase_t                phase_reg;
    logic [3:0]            k_reg;
    logic [1:0]            t_reg;
    logic signed [MW-1:0]  minor_reg [16];
    logic signed [DW-1:0]  det_reg;
    logic signed [PW-1:0]  pair_reg;
    logic signed [MW-1:0]  acc_reg;
    logic [1:0]            sub_reg;
    logic [NW-1:0]         rem_num_reg;
    logic [DW-1:0]         rem_reg;
    logic [NW-1:0]         quo_reg;
    logic [CW-1:0]         bit_reg;
    logic                  qneg_reg;
    logic [3:0]            oi_reg;

    logic [1:0] rw [3];
    logic [1:0] cl [3];
    logic [1:0] sr, sc;
    always_comb begin
        sr = k_reg[1:0];
        sc = k_reg[3:2];
        for (int i = 0; i < 3; i++) begin
            rw[i] = (2'(i) < sr) ? 2'(i) : 2'(i + 1);
            cl[i] = (2'(i) < sc) ? 2'(i) : 2'(i + 1);
        end
    end

    function automatic logic [3:0] ad(input logic [1:0] r, input logic [1:0] c);
        return {c, r};
    endfunction

    logic [1:0] j0, j1, j2;
    always_comb begin
        j0 = t_reg;
        j1 = (t_reg == 2'd2) ? 2'd0 : t_reg + 2'd1;
        j2 = (t_reg == 2'd0) ? 2'd2 : t_reg - 2'd1;
    end

    logic signed [DATA_WIDTH-1:0] mul_a;
    logic signed [BW-1:0]         mul_b;
    logic signed [PR-1:0]         prod;
    logic signed [MW-1:0]         mv;
    logic signed [MW-1:0]         mterm;
    logic signed [DW-1:0]         dterm;
    always_comb begin
        mv    = minor_reg[{t_reg, 2'b00}];
        mul_a = '0;
        mul_b = '0;
        if (phase_reg == P_MIN) begin
            case (sub_reg)
                2'd0: begin
                    mul_a = mem_reg[ad(rw[1], cl[j1])];
                    mul_b = BW'(mem_reg[ad(rw[2], cl[j2])]);
                end
                2'd1: begin
                    mul_a = mem_reg[ad(rw[1], cl[j2])];
                    mul_b = BW'(mem_reg[ad(rw[2], cl[j1])]);
                end
                2'd2: begin
                    mul_a = mem_reg[ad(rw[0], cl[j0])];
                    mul_b = {1'b0, pair_reg[DATA_WIDTH-1:0]};
                end
                default: begin
                    mul_a = mem_reg[ad(rw[0], cl[j0])];
                    mul_b = {pair_reg[PW-1], pair_reg[PW-1:DATA_WIDTH]};
                end
            endcase
        end else if (phase_reg == P_DET) begin
            mul_a = mem_reg[{t_reg, 2'd0}];
            case (sub_reg)
                2'd0:    mul_b = {1'b0, mv[DATA_WIDTH-1:0]};
                2'd1:    mul_b = {1'b0, mv[2*DATA_WIDTH-1:DATA_WIDTH]};
                2'd2:    mul_b = {1'b0, mv[3*DATA_WIDTH-1:2*DATA_WIDTH]};
                default: mul_b = BW'($signed(mv[MW-1:3*DATA_WIDTH]));
            endcase
        end
    end

    assign prod = PR'(mul_a) * PR'(mul_b);

    always_comb begin
        mterm = (sub_reg == 2'd3) ? (MW'(prod) << DATA_WIDTH) : MW'(prod);
        case (sub_reg)
            2'd0:    dterm = DW'(prod);
            2'd1:    dterm = DW'(prod) << DATA_WIDTH;
            2'd2:    dterm = DW'(prod) << (2 * DATA_WIDTH);
            default: dterm = DW'(prod) << (3 * DATA_WIDTH);
        endcase
    end

    logic signed [MW-1:0] adj;
    logic [MW-1:0]        adj_mag;
    logic [DW-1:0]        d_mag;
    logic [3:0]           mi;
    always_comb begin
        mi      = {oi_reg[1:0], oi_reg[3:2]};
        adj     = minor_reg[mi];
        if (oi_reg[0] ^ oi_reg[2]) adj = -adj;
        adj_mag = adj[MW-1] ? MW'(-adj) : MW'(adj);
        d_mag   = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
    end

    logic [DW:0] rs;
    logic [DW:0] diff;
    always_comb begin
        rs   = {rem_reg, rem_num_reg[NW-1]};
        diff = rs - {1'b0, d_mag};
    end

    logic                  out_full_reg;
    logic                  div_done;
    logic                  out_set;
    logic signed [DATA_WIDTH-1:0] sat_val;
    logic                  sat_flag;
    localparam logic [NW-1:0] LIM = NW'(1) << (DATA_WIDTH - 1);
    always_comb begin
        sat_flag = 1'b0;
        if (qneg_reg) begin
            if (quo_reg > LIM) sat_flag = 1'b1;
            sat_val = sat_flag ? DATA_WIDTH'(LIM) : DATA_WIDTH'(-quo_reg);
        end else begin
            if (quo_reg >= LIM) sat_flag = 1'b1;
            sat_val = sat_flag ? DATA_WIDTH'(LIM - 1) : DATA_WIDTH'(quo_reg);
        end
    end
    assign div_done = (phase_reg == P_DIV) && (bit_reg == '0);
    assign out_set  = ((phase_reg == P_OUT) && (det_reg == '0) &&
                       (!out_full_reg || (m_valid && m_ready))) || div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= P_IDLE;
            out_full_reg <= 1'b0;
        end else begin
            if (out_set) out_full_reg <= 1'b1;
            else if (m_valid && m_ready) out_full_reg <= 1'b0;
            unique case (phase_reg)
                P_IDLE: begin
                    if (start) begin
                        phase_reg <= P_MIN;
                        k_reg     <= '0;
                        t_reg     <= '0;
                        sub_reg   <= '0;
                        acc_reg   <= '0;
                    end
                end
                P_MIN: begin
                    sub_reg <= sub_reg + 2'd1;
                    case (sub_reg)
                        2'd0: pair_reg <= PW'(prod);
                        2'd1: pair_reg <= pair_reg - PW'(prod);
                        2'd2: acc_reg  <= acc_reg + mterm;
                        default: begin
                            if (t_reg == 2'd2) begin
                                minor_reg[k_reg] <= acc_reg + mterm;
                                acc_reg <= '0;
                                t_reg   <= '0;
                                k_reg   <= k_reg + 4'd1;
                                if (k_reg == 4'd15) begin
                                    phase_reg <= P_DET;
                                    det_reg   <= '0;
                                end
                            end else begin
                                acc_reg <= acc_reg + mterm;
                                t_reg   <= t_reg + 2'd1;
                            end
                        end
                    endcase
                end
                P_DET: begin
                    det_reg <= t_reg[0] ? det_reg - dterm : det_reg + dterm;
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == 2'd3) begin
                        t_reg <= t_reg + 2'd1;
                        if (t_reg == 2'd3) begin
                            phase_reg <= P_OUT;
                            oi_reg    <= '0;
                        end
                    end
                end
                P_OUT: begin
                    if (!out_full_reg || (m_valid && m_ready)) begin
                        if (det_reg == '0) begin
                            m_value      <= '0;
                            m_index      <= oi_reg;
                            m_singular   <= 1'b1;
                            m_sat        <= 1'b0;
                            m_last       <= (oi_reg == 4'd15);
                            oi_reg       <= oi_reg + 4'd1;
                            if (oi_reg == 4'd15) phase_reg <= P_IDLE;
                        end else begin
                            rem_num_reg <= NW'(adj_mag) << (2 * FRAC_BITS);
                            rem_reg     <= '0;
                            quo_reg     <= '0;
                            bit_reg     <= CW'(NW);
                            qneg_reg    <= adj[MW-1] ^ det_reg[DW-1];
                            phase_reg   <= P_DIV;
                        end
                    end
                end
                P_DIV: begin
                    if (bit_reg != '0) begin
                        rem_num_reg <= rem_num_reg << 1;
                        bit_reg     <= bit_reg - CW'(1);
                        if (!diff[DW]) begin
                            rem_reg <= diff[DW-1:0];
                            quo_reg <= {quo_reg[NW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rs[DW-1:0];
                            quo_reg <= {quo_reg[NW-2:0], 1'b0};
                        end
                    end else begin
                        m_value      <= sat_val;
                        m_index      <= oi_reg;
                        m_singular   <= 1'b0;
                        m_sat        <= sat_flag;
                        m_last       <= (oi_reg == 4'd15);
                        oi_reg       <= oi_reg + 4'd1;
                        phase_reg    <= (oi_reg == 4'd15) ? P_IDLE : P_OUT;
                    end
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    assign m_valid       = out_full_reg;
    assign stat.div_busy = (phase_reg != P_IDLE) || start || div_done;
    assign stat.out_full = out_full_reg;
endmodule
`default_nettype wire

### rtl/mat4_inverse_adjugate.sv
// channel | dir | tdata                 | tuser                                  | tlast
// s_      | in  | element_value [31:0]  | -                                      | -
// m_      | out | inverse_value [31:0]  | element_index[3:0],singular,saturated  | last
// Load: one beat per cycle, 16 beats per matrix, then one start cycle.
// Compute: 16 minors on one shared multiplier, then the determinant, then
// per element a serial restoring divide; a singular matrix skips the
// divide and emits each element as zero with the singular flag set.
// A stalled output beat holds back the next divide; s_tready stays low until
// the last result beat has left.
// Reset: synchronous, active low; clears the load count and control state.
`default_nettype none
module mat4_inverse_adjugate #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [DATA_WIDTH-1:0]   s_tdata,   // element_value
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [DATA_WIDTH-1:0]        m_tdata,   // inverse_value
    output logic [5:0]                   m_tuser,   // element_index[3:0], singular, saturated
    output logic                         m_tlast
);
    import mia_pkg::*;

    status_t    stat;
    logic       start;
    logic [3:0] load_addr;
    logic       in_beat;
    logic signed [DATA_WIDTH-1:0] val;
    logic [3:0] idx;
    logic       sing, sat;

    assign in_beat = s_tvalid && s_tready;

    mia_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_beat(in_beat), .stat(stat),
        .s_ready(s_tready), .start(start), .load_addr(load_addr)
    );

    mia_dp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_beat(in_beat), .load_addr(load_addr),
        .in_value(s_tdata), .start(start), .stat(stat),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_value(val), .m_index(idx),
        .m_singular(sing), .m_sat(sat), .m_last(m_tlast)
    );

    assign m_tdata = val;
    assign m_tuser = {sat, sing, idx};
endmodule
`default_nettype wire

### rtl/mia_checker.sv
`default_nettype none
module mia_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [5:0] m_tuser,
    input wire logic       m_tlast
);
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[3:0] == 4'd15)))
        else $error("tlast mismatch");
    a_sing_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[4] && m_tuser[5]))
        else $error("singular with saturated");
    a_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("load during output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
        else $error("output dropped");
endmodule

bind mat4_inverse_adjugate mia_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
